FILE: sv/rwlm_pkg.sv
// ----------------------------------------------------------------------------
// rwlm_pkg
// Shared types, codes and the lock acquisition rule of the lock manager.
// ----------------------------------------------------------------------------
package rwlm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 8;
    localparam int RC_W        = 8;
    localparam int RES_LIMIT   = 16;

    localparam int QD_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RB_W  = $clog2(RES_LIMIT);
    localparam int RBC_W = $clog2(RES_LIMIT + 1);

    localparam logic [RC_W-1:0] MAX_READERS = RC_W'(255);

    localparam logic [1:0] ACT_LOCK          = 2'd0;
    localparam logic [1:0] ACT_UNLOCK        = 2'd1;
    localparam logic [1:0] ACT_UNLOCK_INTENT = 2'd2;

    localparam logic [2:0] ACC_READ      = 3'd0;
    localparam logic [2:0] ACC_READ_SYNC = 3'd1;
    localparam logic [2:0] ACC_WRITE     = 3'd2;
    localparam logic [2:0] ACC_INTENT    = 3'd3;
    localparam logic [2:0] ACC_UPGRADE   = 3'd4;

    typedef logic [TAG_WIDTH-1:0] t_tag;

    typedef enum logic [1:0] {
        M_UNLOCKED = 2'd0,
        M_READING  = 2'd1,
        M_WRITING  = 2'd2,
        M_INTENT   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        K_GRANT_NOW = 3'd0,
        K_QUEUED    = 3'd1,
        K_FULL      = 3'd2,
        K_GRANT_Q   = 3'd3,
        K_RELEASED  = 3'd4,
        K_ERROR     = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        OP_LOCK,
        OP_UNLOCK,
        OP_UNLOCK_INTENT,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        RES_GRANT,
        RES_BLOCK,
        RES_FAULT
    } t_res;

    typedef struct packed {
        t_op        op;
        logic [2:0] access;
        t_tag       tag;
    } t_cmd;

    typedef struct packed {
        t_res            res;
        t_mode           mode;
        logic [RC_W-1:0] rc;
    } t_try;

    // fresh requests other than upgrades also defer to a conflicting write, read or intent head of the wait queue
    function automatic t_try try_acquire(
        input logic [2:0]      acc,
        input logic            fresh,
        input logic            head_vld,
        input logic [2:0]      head_acc,
        input t_mode           mode,
        input logic [RC_W-1:0] rc
    );
        t_try r;
        logic hw;
        logic hr;
        logic hi;
        hw = fresh && head_vld && (head_acc == ACC_WRITE);
        hr = fresh && head_vld && (head_acc == ACC_READ);
        hi = fresh && head_vld && (head_acc == ACC_INTENT);
        r.res  = RES_BLOCK;
        r.mode = mode;
        r.rc   = rc;
        case (acc) inside
            ACC_READ, ACC_READ_SYNC: begin
                if (hw || mode == M_WRITING) begin
                    r.res = RES_BLOCK;
                end else if (rc >= MAX_READERS) begin
                    r.res = fresh ? RES_FAULT : RES_BLOCK;
                end else begin
                    r.res  = RES_GRANT;
                    r.mode = (mode == M_UNLOCKED) ? M_READING : mode;
                    r.rc   = rc + 1'b1;
                end
            end
            ACC_WRITE: begin
                if (!(hw || hr || hi) && mode == M_UNLOCKED) begin
                    r.res  = RES_GRANT;
                    r.mode = M_WRITING;
                end
            end
            ACC_INTENT: begin
                if (!(hw || hi) && (mode == M_UNLOCKED || mode == M_READING)) begin
                    r.res  = RES_GRANT;
                    r.mode = M_INTENT;
                end
            end
            ACC_UPGRADE: begin
                if (mode != M_INTENT) begin
                    r.res = RES_FAULT;
                end else if (rc == '0) begin
                    r.res  = RES_GRANT;
                    r.mode = M_WRITING;
                end
            end
            default: r.res = RES_FAULT;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/rwlm_req_if.sv
// ----------------------------------------------------------------------------
// rwlm_req_if
// Request channel of the lock manager: action, access and requester tag.
// ----------------------------------------------------------------------------
interface rwlm_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [2:0]           access;
    rwlm_pkg::t_tag       requester_tag;

    modport source (output valid, output action, output access, output requester_tag,
                    input ready);
    modport sink   (input valid, input action, input access, input requester_tag,
                    output ready);
endinterface

FILE: sv/rwlm_rsp_if.sv
// ----------------------------------------------------------------------------
// rwlm_rsp_if
// Result channel of the lock manager.
// ----------------------------------------------------------------------------
interface rwlm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 kind;
    rwlm_pkg::t_tag             grant_tag;
    logic                       last;
    logic [1:0]                 lock_mode;
    logic [rwlm_pkg::RC_W-1:0]  readers;

    modport source (output valid, output kind, output grant_tag, output last,
                    output lock_mode, output readers, input ready);
    modport sink   (input valid, input kind, input grant_tag, input last,
                    input lock_mode, input readers, output ready);
endinterface

FILE: sv/rwlm_front.sv
// ----------------------------------------------------------------------------
// rwlm_front
// Accepts requests, decodes them into commands and holds them in a two-entry
// queue for the execution engine.
// ----------------------------------------------------------------------------
module rwlm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rwlm_req_if.sink       i_req,
    output logic           o_cmd_valid,
    output rwlm_pkg::t_cmd o_cmd,
    input  logic           i_cmd_pop
);

    rwlm_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    rwlm_pkg::t_cmd dec;
    logic           push;
    logic           pop;

    always_comb begin
        dec.access = i_req.access;
        dec.tag    = i_req.requester_tag;
        unique case (i_req.action)
            rwlm_pkg::ACT_LOCK: begin
                dec.op = (i_req.access > rwlm_pkg::ACC_UPGRADE) ? rwlm_pkg::OP_BAD
                                                                : rwlm_pkg::OP_LOCK;
            end
            rwlm_pkg::ACT_UNLOCK:        dec.op = rwlm_pkg::OP_UNLOCK;
            rwlm_pkg::ACT_UNLOCK_INTENT: dec.op = rwlm_pkg::OP_UNLOCK_INTENT;
            default:                     dec.op = rwlm_pkg::OP_BAD;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: sv/rwlm_back.sv
// ----------------------------------------------------------------------------
// rwlm_back
// Execution engine: drains the wait queue, carries out the command, drains
// again after a release, collects the results and plays them out.
// ----------------------------------------------------------------------------
module rwlm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  rwlm_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    rwlm_rsp_if.source     o_rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN_PRE,
        ST_ACTION,
        ST_DRAIN_POST,
        ST_REPLY
    } t_state;

    localparam int QD_W  = rwlm_pkg::QD_W;
    localparam int QC_W  = rwlm_pkg::QC_W;
    localparam int RB_W  = rwlm_pkg::RB_W;
    localparam int RBC_W = rwlm_pkg::RBC_W;
    localparam int RC_W  = rwlm_pkg::RC_W;

    // wait queue and result buffer
    logic [2:0]      r_wq_acc [rwlm_pkg::QUEUE_DEPTH];
    rwlm_pkg::t_tag  r_wq_tag [rwlm_pkg::QUEUE_DEPTH];
    rwlm_pkg::t_kind r_rb_kind [rwlm_pkg::RES_LIMIT];
    rwlm_pkg::t_tag  r_rb_tag  [rwlm_pkg::RES_LIMIT];

    t_state            r_state,   n_state;
    rwlm_pkg::t_mode   r_mode,    n_mode;
    logic [RC_W-1:0]   r_rc,      n_rc;
    logic [QD_W-1:0]   r_head,    n_head;
    logic [QD_W-1:0]   r_tail,    n_tail;
    logic [QC_W-1:0]   r_wcnt,    n_wcnt;
    rwlm_pkg::t_cmd    r_cmd,     n_cmd;
    logic              r_pending, n_pending;
    logic [RBC_W-1:0]  r_res_cnt, n_res_cnt;
    logic [RBC_W-1:0]  r_k,       n_k;
    logic              r_ov,      n_ov;
    rwlm_pkg::t_kind   r_o_kind,  n_o_kind;
    rwlm_pkg::t_tag    r_o_tag,   n_o_tag;
    logic              r_o_last,  n_o_last;
    rwlm_pkg::t_mode   r_o_mode,  n_o_mode;
    logic [RC_W-1:0]   r_o_rc,    n_o_rc;

    logic            rb_we;
    rwlm_pkg::t_kind rb_kind;
    rwlm_pkg::t_tag  rb_tag;
    logic            wq_we;

    logic            head_vld;
    logic [2:0]      head_acc;
    rwlm_pkg::t_tag  head_tag;
    rwlm_pkg::t_try  t_head;
    rwlm_pkg::t_try  t_fresh;
    rwlm_pkg::t_res  lock_res;
    logic [QD_W-1:0] head_inc;
    logic [QD_W-1:0] tail_inc;

    assign head_vld = (r_wcnt != '0);
    assign head_acc = r_wq_acc[r_head];
    assign head_tag = r_wq_tag[r_head];
    assign head_inc = (r_head == QD_W'(rwlm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == QD_W'(rwlm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    assign t_head  = rwlm_pkg::try_acquire(head_acc, 1'b0, 1'b0, rwlm_pkg::ACC_READ,
                                           r_mode, r_rc);
    assign t_fresh = rwlm_pkg::try_acquire(r_cmd.access, 1'b1, head_vld, head_acc,
                                           r_mode, r_rc);
    assign lock_res = (r_pending && r_cmd.access != rwlm_pkg::ACC_UPGRADE)
                      ? rwlm_pkg::RES_BLOCK : t_fresh.res;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_rc      = r_rc;
        n_head    = r_head;
        n_tail    = r_tail;
        n_wcnt    = r_wcnt;
        n_cmd     = r_cmd;
        n_pending = r_pending;
        n_res_cnt = r_res_cnt;
        n_k       = r_k;
        n_ov      = r_ov && !o_rsp.ready;
        n_o_kind  = r_o_kind;
        n_o_tag   = r_o_tag;
        n_o_last  = r_o_last;
        n_o_mode  = r_o_mode;
        n_o_rc    = r_o_rc;
        rb_we     = 1'b0;
        rb_kind   = rwlm_pkg::K_ERROR;
        rb_tag    = r_cmd.tag;
        wq_we     = 1'b0;
        o_cmd_pop = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_res_cnt = '0;
                    n_k       = '0;
                    n_state   = ST_DRAIN_PRE;
                end
            end
            ST_DRAIN_PRE: begin
                if (!head_vld) begin
                    n_pending = 1'b0;
                    n_state   = ST_ACTION;
                end else if (r_res_cnt == RBC_W'(rwlm_pkg::RES_LIMIT - 1)) begin
                    // keep room for the command's own result
                    n_pending = (t_head.res != rwlm_pkg::RES_BLOCK);
                    n_state   = ST_ACTION;
                end else if (t_head.res == rwlm_pkg::RES_BLOCK) begin
                    n_pending = 1'b0;
                    n_state   = ST_ACTION;
                end else begin
                    rb_we     = 1'b1;
                    rb_kind   = (t_head.res == rwlm_pkg::RES_GRANT) ? rwlm_pkg::K_GRANT_Q
                                                                    : rwlm_pkg::K_ERROR;
                    rb_tag    = head_tag;
                    n_res_cnt = r_res_cnt + 1'b1;
                    n_mode    = t_head.mode;
                    n_rc      = t_head.rc;
                    n_head    = head_inc;
                    n_wcnt    = r_wcnt - 1'b1;
                end
            end
            ST_ACTION: begin
                rb_we     = 1'b1;
                n_res_cnt = r_res_cnt + 1'b1;
                n_state   = ST_REPLY;
                unique case (r_cmd.op)
                    rwlm_pkg::OP_LOCK: begin
                        case (lock_res)
                            rwlm_pkg::RES_GRANT: begin
                                rb_kind = rwlm_pkg::K_GRANT_NOW;
                                n_mode  = t_fresh.mode;
                                n_rc    = t_fresh.rc;
                            end
                            rwlm_pkg::RES_FAULT: rb_kind = rwlm_pkg::K_ERROR;
                            default: begin
                                if (r_wcnt >= QC_W'(rwlm_pkg::QUEUE_DEPTH)) begin
                                    rb_kind = rwlm_pkg::K_FULL;
                                end else begin
                                    rb_kind = rwlm_pkg::K_QUEUED;
                                    wq_we   = 1'b1;
                                    n_tail  = tail_inc;
                                    n_wcnt  = r_wcnt + 1'b1;
                                end
                            end
                        endcase
                    end
                    rwlm_pkg::OP_UNLOCK: begin
                        if (r_mode == rwlm_pkg::M_WRITING) begin
                            rb_kind = rwlm_pkg::K_RELEASED;
                            n_mode  = rwlm_pkg::M_UNLOCKED;
                            n_state = ST_DRAIN_POST;
                        end else if (r_mode != rwlm_pkg::M_UNLOCKED && r_rc != '0) begin
                            rb_kind = rwlm_pkg::K_RELEASED;
                            n_rc    = r_rc - 1'b1;
                            if (r_mode == rwlm_pkg::M_READING && r_rc == RC_W'(1)) begin
                                n_mode = rwlm_pkg::M_UNLOCKED;
                            end
                            n_state = ST_DRAIN_POST;
                        end
                    end
                    rwlm_pkg::OP_UNLOCK_INTENT: begin
                        if (r_mode == rwlm_pkg::M_INTENT) begin
                            rb_kind = rwlm_pkg::K_RELEASED;
                            n_mode  = (r_rc != '0) ? rwlm_pkg::M_READING
                                                   : rwlm_pkg::M_UNLOCKED;
                            n_state = ST_DRAIN_POST;
                        end
                    end
                    default: rb_kind = rwlm_pkg::K_ERROR;
                endcase
            end
            ST_DRAIN_POST: begin
                if (!head_vld || r_res_cnt == RBC_W'(rwlm_pkg::RES_LIMIT)
                        || t_head.res == rwlm_pkg::RES_BLOCK) begin
                    n_state = ST_REPLY;
                end else begin
                    rb_we     = 1'b1;
                    rb_kind   = (t_head.res == rwlm_pkg::RES_GRANT) ? rwlm_pkg::K_GRANT_Q
                                                                    : rwlm_pkg::K_ERROR;
                    rb_tag    = head_tag;
                    n_res_cnt = r_res_cnt + 1'b1;
                    n_mode    = t_head.mode;
                    n_rc      = t_head.rc;
                    n_head    = head_inc;
                    n_wcnt    = r_wcnt - 1'b1;
                end
            end
            ST_REPLY: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov     = 1'b1;
                    n_o_kind = r_rb_kind[r_k[RB_W-1:0]];
                    n_o_tag  = r_rb_tag[r_k[RB_W-1:0]];
                    n_o_last = (r_k + 1'b1 == r_res_cnt);
                    n_o_mode = r_mode;
                    n_o_rc   = r_rc;
                    n_k      = r_k + 1'b1;
                    if (r_k + 1'b1 == r_res_cnt) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            r_wq_acc[r_tail] <= r_cmd.access;
            r_wq_tag[r_tail] <= r_cmd.tag;
        end
        if (rb_we) begin
            r_rb_kind[r_res_cnt[RB_W-1:0]] <= rb_kind;
            r_rb_tag[r_res_cnt[RB_W-1:0]]  <= rb_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= rwlm_pkg::M_UNLOCKED;
            r_rc      <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_wcnt    <= '0;
            r_pending <= 1'b0;
            r_res_cnt <= '0;
            r_k       <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_rc      <= n_rc;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_wcnt    <= n_wcnt;
            r_pending <= n_pending;
            r_res_cnt <= n_res_cnt;
            r_k       <= n_k;
            r_ov      <= n_ov;
        end
        r_cmd    <= n_cmd;
        r_o_kind <= n_o_kind;
        r_o_tag  <= n_o_tag;
        r_o_last <= n_o_last;
        r_o_mode <= n_o_mode;
        r_o_rc   <= n_o_rc;
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.kind      = r_o_kind;
    assign o_rsp.grant_tag = r_o_tag;
    assign o_rsp.last      = r_o_last;
    assign o_rsp.lock_mode = r_o_mode;
    assign o_rsp.readers   = r_o_rc;

endmodule

FILE: sv/read_write_intent_lock_manager_unit.sv
// ----------------------------------------------------------------------------
// read_write_intent_lock_manager_unit
// Reader/writer lock manager with upgradable intent and a 16-entry wait queue.
// ----------------------------------------------------------------------------
// Each request yields one to sixteen result transactions, the final one marked
// by last; all of them report the lock mode and reader count after the request.
// A request is decoded into a two-entry command queue, so the input accepts up
// to two requests ahead of the engine. The engine handles one command at a time:
// it picks the command up, serves queued waiters from the head of the wait
// queue until one blocks or the result buffer fills, carries out the command,
// after a release serves queued waiters again in the same way, then plays the
// results out through the output register. The wait queue walk takes one entry
// per cycle, and result playback one per cycle while the output is ready.
module read_write_intent_lock_manager_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwlm_req_if.sink   i_req,
    rwlm_rsp_if.source o_rsp
);

    logic           cmd_valid;
    rwlm_pkg::t_cmd cmd;
    logic           cmd_pop;

    rwlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    rwlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the read/write/intent lock manager. A queue of lock
// and unlock transactions is fed to the request channel. Every accepted
// transaction updates a local copy of the lock state and wait queue and
// appends the results it must cause. Each result transaction is checked field
// by field against the oldest of those. Both channels idle at random in phases.
// ----------------------------------------------------------------------------
module testbench;
    import rwlm_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        GOT,
        WAITS,
        BAD
    } t_verdict;

    typedef struct {
        logic [1:0] action;
        logic [2:0] access;
        t_tag       tag;
        bit         hold;
    } t_lock_req;

    typedef struct {
        t_kind           kind;
        t_tag            tag;
        logic            last;
        t_mode           mode;
        logic [RC_W-1:0] readers;
    } t_lock_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rwlm_req_if req_if ();
    rwlm_rsp_if rsp_if ();

    read_write_intent_lock_manager_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // lock state as the block should hold it
    t_mode           lk_mode    = M_UNLOCKED;
    logic [RC_W-1:0] lk_readers = '0;
    logic [2:0]      wq_acc [QUEUE_DEPTH];
    t_tag            wq_tag [QUEUE_DEPTH];
    int              wq_head    = 0;
    int              wq_tail    = 0;
    int              wq_cnt     = 0;

    t_lock_rsp step_rsps [$];
    t_lock_rsp due_rsps  [$];
    t_lock_req pending_reqs [$];

    int n_errors    = 0;
    int n_accepted  = 0;
    int n_presented = 0;

    function automatic t_verdict grab_lock(input logic [2:0] acc, input bit fresh);
        bit         hd;
        logic [2:0] ha;
        hd = fresh && (wq_cnt > 0);
        ha = wq_acc[wq_head];
        case (acc)
            ACC_READ, ACC_READ_SYNC: begin
                if ((hd && ha == ACC_WRITE) || lk_mode == M_WRITING) return WAITS;
                if (lk_readers >= MAX_READERS) return fresh ? BAD : WAITS;
                if (lk_mode == M_UNLOCKED) lk_mode = M_READING;
                lk_readers = lk_readers + 1'b1;
                return GOT;
            end
            ACC_WRITE: begin
                if (hd && (ha == ACC_WRITE || ha == ACC_READ || ha == ACC_INTENT))
                    return WAITS;
                if (lk_mode != M_UNLOCKED) return WAITS;
                lk_mode = M_WRITING;
                return GOT;
            end
            ACC_INTENT: begin
                if (hd && (ha == ACC_WRITE || ha == ACC_INTENT)) return WAITS;
                if (lk_mode != M_UNLOCKED && lk_mode != M_READING) return WAITS;
                lk_mode = M_INTENT;
                return GOT;
            end
            ACC_UPGRADE: begin
                if (lk_mode != M_INTENT) return BAD;
                if (lk_readers != '0) return WAITS;
                lk_mode = M_WRITING;
                return GOT;
            end
            default: return BAD;
        endcase
        return BAD;
    endfunction

    function automatic void note(input t_kind kind, input t_tag tag);
        t_lock_rsp e;
        e = '{kind, tag, 1'b0, lk_mode, lk_readers};
        if (step_rsps.size() < RES_LIMIT)
            step_rsps = {step_rsps, e};
    endfunction

    // grants waiters from the head until one blocks or the result budget is used;
    // reports whether the head could still go
    function automatic bit drain_waiters(input int limit);
        t_verdict        v;
        t_mode           sm;
        logic [RC_W-1:0] sr;
        while (wq_cnt > 0) begin
            if (step_rsps.size() >= limit) begin
                sm = lk_mode;
                sr = lk_readers;
                v = grab_lock(wq_acc[wq_head], 1'b0);
                lk_mode    = sm;
                lk_readers = sr;
                return v != WAITS;
            end
            v = grab_lock(wq_acc[wq_head], 1'b0);
            if (v == WAITS) return 1'b0;
            note(v == GOT ? K_GRANT_Q : K_ERROR, wq_tag[wq_head]);
            wq_head = (wq_head + 1) % QUEUE_DEPTH;
            wq_cnt--;
        end
        return 1'b0;
    endfunction

    function automatic void lock_step(input logic [1:0] act, input logic [2:0] acc,
                                      input t_tag tag);
        bit       pend;
        bit       ok;
        t_verdict v;
        step_rsps.delete();
        pend = drain_waiters(RES_LIMIT - 1);
        case (act)
            ACT_LOCK: begin
                if (acc > ACC_UPGRADE) begin
                    note(K_ERROR, tag);
                end else begin
                    v = (pend && acc != ACC_UPGRADE) ? WAITS : grab_lock(acc, 1'b1);
                    if (v == GOT) begin
                        note(K_GRANT_NOW, tag);
                    end else if (v == BAD) begin
                        note(K_ERROR, tag);
                    end else if (wq_cnt >= QUEUE_DEPTH) begin
                        note(K_FULL, tag);
                    end else begin
                        wq_acc[wq_tail] = acc;
                        wq_tag[wq_tail] = tag;
                        wq_tail = (wq_tail + 1) % QUEUE_DEPTH;
                        wq_cnt++;
                        note(K_QUEUED, tag);
                    end
                end
            end
            ACT_UNLOCK: begin
                ok = 1'b1;
                case (lk_mode)
                    M_UNLOCKED: ok = 1'b0;
                    M_READING: begin
                        if (lk_readers == '0) begin
                            ok = 1'b0;
                        end else begin
                            lk_readers = lk_readers - 1'b1;
                            if (lk_readers == '0) lk_mode = M_UNLOCKED;
                        end
                    end
                    M_WRITING: lk_mode = M_UNLOCKED;
                    M_INTENT: begin
                        if (lk_readers == '0) ok = 1'b0;
                        else lk_readers = lk_readers - 1'b1;
                    end
                endcase
                if (ok) begin
                    note(K_RELEASED, tag);
                    void'(drain_waiters(RES_LIMIT));
                end else begin
                    note(K_ERROR, tag);
                end
            end
            ACT_UNLOCK_INTENT: begin
                if (lk_mode != M_INTENT) begin
                    note(K_ERROR, tag);
                end else begin
                    lk_mode = (lk_readers != '0) ? M_READING : M_UNLOCKED;
                    note(K_RELEASED, tag);
                    void'(drain_waiters(RES_LIMIT));
                end
            end
            default: note(K_ERROR, tag);
        endcase
        foreach (step_rsps[k]) begin
            step_rsps[k].last    = (k == step_rsps.size() - 1);
            step_rsps[k].mode    = lk_mode;
            step_rsps[k].readers = lk_readers;
            due_rsps = {due_rsps, step_rsps[k]};
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    function automatic void queue_req(input logic [1:0] act, input logic [2:0] acc,
                                      input t_tag tag, input bit hold = 1'b0);
        t_lock_req e;
        e = '{act, acc, tag, hold};
        pending_reqs = {pending_reqs, e};
    endfunction

    function automatic logic [2:0] pick_access();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return (r % 2) ? ACC_READ_SYNC : ACC_READ;
        if (r < 55) return ACC_WRITE;
        if (r < 72) return ACC_INTENT;
        if (r < 92) return ACC_UPGRADE;
        return 3'($urandom_range(ACC_UPGRADE + 1, 7));
    endfunction

    function automatic void push_random(input int unlock_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < unlock_w)
            queue_req(ACT_UNLOCK, 3'($urandom), t_tag'($urandom));
        else if (r < unlock_w + 10)
            queue_req(ACT_UNLOCK_INTENT, 3'($urandom), t_tag'($urandom));
        else if (r < unlock_w + 14)
            queue_req(ACT_UNKNOWN, 3'($urandom), t_tag'($urandom));
        else
            queue_req(ACT_LOCK, pick_access(), t_tag'($urandom));
    endfunction

    // idle pattern changes every 40 accepted transactions
    function automatic bit roll_idle(input bit is_sender);
        int phase;
        phase = (n_accepted / 40) % 4;
        if (phase == 3) return $urandom_range(0, 99) < 29;
        if (phase == (is_sender ? 1 : 2)) return $urandom_range(0, 99) < 53;
        return 1'b0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_if.valid || n_accepted == n_presented) begin
                if (pending_reqs.size() > 0 && !roll_idle(1'b1) &&
                    !(pending_reqs[0].hold && due_rsps.size() > 0)) begin
                    req_if.valid         <= 1'b1;
                    req_if.action        <= pending_reqs[0].action;
                    req_if.access        <= pending_reqs[0].access;
                    req_if.requester_tag <= pending_reqs[0].tag;
                    void'(pending_reqs.pop_front());
                    n_presented++;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= !roll_idle(1'b0);
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_lock_rsp want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_rsps.size() == 0) begin
                    $error("unexpected result: kind %0d tag %0d", rsp_if.kind,
                           rsp_if.grant_tag);
                    n_errors++;
                end else begin
                    want = due_rsps.pop_front();
                    check_field("kind", 16'(want.kind), 16'(rsp_if.kind));
                    check_field("grant_tag", 16'(want.tag), 16'(rsp_if.grant_tag));
                    check_field("last", 16'(want.last), 16'(rsp_if.last));
                    check_field("lock_mode", 16'(want.mode), 16'(rsp_if.lock_mode));
                    check_field("readers", 16'(want.readers), 16'(rsp_if.readers));
                end
            end
            if (req_if.valid && req_if.ready) begin
                lock_step(req_if.action, req_if.access, req_if.requester_tag);
                n_accepted++;
            end
        end
    end

    initial begin
        int n;
        req_if.valid         = 1'b0;
        req_if.action        = ACT_LOCK;
        req_if.access        = ACC_READ;
        req_if.requester_tag = '0;
        rsp_if.ready         = 1'b0;

        // misuse and the intent / upgrade paths
        queue_req(ACT_UNLOCK, ACC_READ, 8'h00);
        queue_req(ACT_UNLOCK_INTENT, ACC_READ, 8'hff);
        queue_req(ACT_UNKNOWN, ACC_WRITE, 8'h11);
        queue_req(ACT_LOCK, 3'(ACC_UPGRADE + 1), 8'h22);
        queue_req(ACT_LOCK, 3'd7, 8'h33);
        queue_req(ACT_LOCK, ACC_UPGRADE, 8'h44);
        queue_req(ACT_LOCK, ACC_INTENT, 8'h55);
        queue_req(ACT_LOCK, ACC_READ, 8'h66);
        queue_req(ACT_LOCK, ACC_UPGRADE, 8'h77);
        queue_req(ACT_UNLOCK_INTENT, ACC_READ, 8'h88);
        queue_req(ACT_UNLOCK, ACC_READ, 8'h99);
        queue_req(ACT_LOCK, ACC_INTENT, 8'haa);
        queue_req(ACT_LOCK, ACC_READ_SYNC, 8'hbb);
        queue_req(ACT_LOCK, ACC_UPGRADE, 8'hcc);
        queue_req(ACT_UNLOCK, ACC_READ, 8'hdd);
        queue_req(ACT_UNLOCK, ACC_READ, 8'hee);
        queue_req(ACT_LOCK, ACC_INTENT, 8'h01);
        queue_req(ACT_LOCK, ACC_UPGRADE, 8'hfe);
        queue_req(ACT_UNLOCK, ACC_READ, 8'h80);

        // reader count up to its limit, then past it
        queue_req(ACT_LOCK, ACC_INTENT, t_tag'($urandom), 1'b1);
        repeat (256) queue_req(ACT_LOCK, $urandom_range(0, 1) ? ACC_READ : ACC_READ_SYNC,
                               t_tag'($urandom));
        queue_req(ACT_LOCK, ACC_WRITE, t_tag'($urandom));
        queue_req(ACT_LOCK, ACC_READ, t_tag'($urandom));
        queue_req(ACT_UNLOCK_INTENT, ACC_READ, t_tag'($urandom));
        repeat (70) push_random(80);

        // writer holds while the wait queue fills, then one release drains waiters from its head
        repeat (6) begin
            queue_req(ACT_LOCK, ACC_WRITE, t_tag'($urandom), 1'b1);
            n = $urandom_range(12, 18);
            repeat (n) queue_req(ACT_LOCK, ($urandom_range(0, 3) == 0) ? pick_access() :
                                 ACC_READ, t_tag'($urandom));
            queue_req(ACT_UNLOCK, 3'($urandom), t_tag'($urandom));
            repeat (8) push_random(30);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || n_accepted != n_presented) @(posedge i_clk);
        while (due_rsps.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rwlm_pkg.sv
sv/rwlm_req_if.sv
sv/rwlm_rsp_if.sv
sv/rwlm_front.sv
sv/rwlm_back.sv
sv/read_write_intent_lock_manager_unit.sv
sim/testbench.sv
